@@ rtl/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared constants and types for the two-class oldest-first FIFO.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int FIELD_W     = 16;
  localparam int SEQ_W       = 6;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = SEQ_W + ID_BITS;

  localparam logic       CMD_ENQ     = 1'b0;
  localparam logic       CMD_DEQ     = 1'b1;
  localparam logic [1:0] WANT_ANY    = 2'd0;
  localparam logic [1:0] WANT_A      = 2'd1;
  localparam logic [1:0] WANT_B      = 2'd2;
  localparam logic [1:0] WANT_NONE   = 2'd3;
  localparam logic       STAT_DEQ    = 1'b0;
  localparam logic       STAT_DROP   = 1'b1;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_DEQ
  } state_t;

endpackage

@@ rtl/two_class_fifo_oldest_first.sv @@
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two FIFOs of signed IDs; dequeue by class or oldest-first across both.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): in_cmd selects enqueue or dequeue.
// An enqueue puts in_item_id in queue A when positive, else in queue B, and
// tags it with a 6-bit arrival number. A full queue drops the ID and returns
// it with out_status set. A dequeue pops the head of A, of B, or the head of
// earlier arrival number mod 64; an empty dequeue gives no transaction.
// Result channel (out_valid / out_stall): out_id and out_status, held in an
// output register until taken.
// An enqueue is written into its queue when accepted, and a dropped ID appears
// on the next cycle. A dequeue reads the head entries out of the entry
// memories into registers as it enters ST_DEQ, where the pop is decided and
// written to the output register. The block takes 1 enqueue per cycle
// unless the receiver stalls a held result, and no request while in ST_DEQ.
// When the receiver stalls with a result held, in_stall rises and the block
// waits. Reset empties both queues and zeroes the arrival number; the entry
// memories are not cleared.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic signed [tcf_pkg::FIELD_W-1:0] in_item_id,
  input  logic [1:0]                   in_want_class,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [tcf_pkg::FIELD_W-1:0] out_id,
  output logic                         out_status
);
  import tcf_pkg::*;

  state_t state_r, state_nxt;

  ptr_t a_head_r, a_head_nxt, b_head_r, b_head_nxt;
  cnt_t a_cnt_r, a_cnt_nxt, b_cnt_r, b_cnt_nxt;
  seq_t arr_r, arr_nxt;
  logic [1:0] want_r, want_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [FIELD_W-1:0] out_id_r, out_id_nxt;
  logic                      out_status_r, out_status_nxt;

  entry_t a_mem [QUEUE_DEPTH];
  entry_t b_mem [QUEUE_DEPTH];
  entry_t a_rd_r, b_rd_r;

  logic   a_we, b_we;
  ptr_t   a_tail, b_tail;
  entry_t wr_entry;

  logic                      accept;
  logic                      out_free;
  logic signed [ID_BITS-1:0] enq_id;
  logic                      enq_cls_a;
  logic                      deq_hit;
  logic                      take_a;
  seq_t                      seq_diff;
  logic signed [ID_BITS-1:0] pop_id;

  function automatic ptr_t ptr_add(ptr_t base, cnt_t offs);
    logic [CNT_W:0] sum;
    sum = {1'b0, CNT_W'(base)} + {1'b0, offs};
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

  assign out_free  = !(out_valid_r && out_stall);
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign enq_id    = ID_BITS'(in_item_id);
  assign enq_cls_a = (enq_id != '0) && !enq_id[ID_BITS-1];
  assign a_tail    = ptr_add(a_head_r, a_cnt_r);
  assign b_tail    = ptr_add(b_head_r, b_cnt_r);
  assign wr_entry  = {arr_r, enq_id};
  assign seq_diff  = b_rd_r[ENTRY_W-1:ID_BITS] - a_rd_r[ENTRY_W-1:ID_BITS];

  always_comb begin
    deq_hit = 1'b0;
    unique case (in_want_class)
      WANT_ANY: deq_hit = (a_cnt_r != '0) || (b_cnt_r != '0);
      WANT_A:   deq_hit = (a_cnt_r != '0);
      WANT_B:   deq_hit = (b_cnt_r != '0);
      default:  deq_hit = 1'b0;
    endcase
  end

  always_comb begin
    take_a = 1'b0;
    unique case (want_r)
      WANT_A:  take_a = 1'b1;
      WANT_B:  take_a = 1'b0;
      default: begin
        if (a_cnt_r == '0) begin
          take_a = 1'b0;
        end else if (b_cnt_r == '0) begin
          take_a = 1'b1;
        end else begin
          take_a = (seq_diff != '0) && !seq_diff[SEQ_W-1];
        end
      end
    endcase
    pop_id = take_a ? ID_BITS'(a_rd_r[ID_BITS-1:0]) : ID_BITS'(b_rd_r[ID_BITS-1:0]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_DEQ && deq_hit) begin
          state_nxt = ST_DEQ;
        end
      end
      ST_DEQ: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    a_we           = 1'b0;
    b_we           = 1'b0;
    a_head_nxt     = a_head_r;
    b_head_nxt     = b_head_r;
    a_cnt_nxt      = a_cnt_r;
    b_cnt_nxt      = b_cnt_r;
    arr_nxt        = arr_r;
    want_nxt       = want_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_ENQ) begin
          if (enq_cls_a && a_cnt_r != CNT_W'(QUEUE_DEPTH)) begin
            a_we      = 1'b1;
            a_cnt_nxt = a_cnt_r + 1'b1;
            arr_nxt   = arr_r + 1'b1;
          end else if (!enq_cls_a && b_cnt_r != CNT_W'(QUEUE_DEPTH)) begin
            b_we      = 1'b1;
            b_cnt_nxt = b_cnt_r + 1'b1;
            arr_nxt   = arr_r + 1'b1;
          end else begin
            out_valid_nxt  = 1'b1;
            out_id_nxt     = FIELD_W'(enq_id);
            out_status_nxt = STAT_DROP;
          end
        end else if (accept) begin
          want_nxt = in_want_class;
        end
      end
      ST_DEQ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = FIELD_W'(pop_id);
          out_status_nxt = STAT_DEQ;
          if (take_a) begin
            a_head_nxt = ptr_add(a_head_r, CNT_W'(1));
            a_cnt_nxt  = a_cnt_r - 1'b1;
          end else begin
            b_head_nxt = ptr_add(b_head_r, CNT_W'(1));
            b_cnt_nxt  = b_cnt_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_tail] <= wr_entry;
    end
    if (b_we) begin
      b_mem[b_tail] <= wr_entry;
    end
    a_rd_r <= a_mem[a_head_r];
    b_rd_r <= b_mem[b_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_head_r    <= '0;
      b_head_r    <= '0;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      arr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_head_r    <= a_head_nxt;
      b_head_r    <= b_head_nxt;
      a_cnt_r     <= a_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      arr_r       <= arr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r       <= want_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_status_r;

endmodule

@@ dv/tcf_order_checker.sv @@
// ----------------------------------------------------------------------------
// tcf_order_checker
// Watches both channels of the two-class oldest-first FIFO. It keeps its own
// copy of both class queues and their arrival tags, predicts the release each
// accepted request causes, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module tcf_order_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_cmd,
  input  logic signed [tcf_pkg::FIELD_W-1:0] in_item_id,
  input  logic [1:0]                         in_want_class,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [tcf_pkg::FIELD_W-1:0] out_id,
  input  logic                               out_status,
  output int                                 fail_count,
  output int                                 pending_count
);
  import tcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam seq_t SEQ_HALF = 6'd32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] id;
    seq_t                      tag;
  } held_id_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] id;
    logic                      status;
  } release_t;

  held_id_t class_a[$];
  held_id_t class_b[$];
  release_t expected_releases[$];
  seq_t     arrival_tag;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    arrival_tag   = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int wanted);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, wanted);
    fail_count++;
  endtask

  task automatic predict_release(input logic cmd, input logic signed [FIELD_W-1:0] item_id,
                                 input logic [1:0] want);
    held_id_t head;
    release_t rel;
    logic     take_a;
    logic     found;
    seq_t     gap;
    take_a = 1'b0;
    found  = 1'b0;
    if (cmd == CMD_ENQ) begin
      if (item_id > 0 ? class_a.size() >= QUEUE_DEPTH : class_b.size() >= QUEUE_DEPTH) begin
        rel.id     = item_id;
        rel.status = STAT_DROP;
        expected_releases = {expected_releases, rel};
      end else begin
        head.id  = item_id;
        head.tag = arrival_tag;
        if (item_id > 0) begin
          class_a = {class_a, head};
        end else begin
          class_b = {class_b, head};
        end
        arrival_tag = arrival_tag + 1'b1;
      end
    end else begin
      case (want)
        WANT_A: begin
          found  = class_a.size() != 0;
          take_a = 1'b1;
        end
        WANT_B: begin
          found = class_b.size() != 0;
        end
        WANT_ANY: begin
          found = class_a.size() != 0 || class_b.size() != 0;
          if (class_b.size() == 0) begin
            take_a = 1'b1;
          end else if (class_a.size() != 0) begin
            gap    = class_b[0].tag - class_a[0].tag;
            take_a = gap != '0 && gap < SEQ_HALF;
          end
        end
        default: begin
          found = 1'b0;
        end
      endcase
      if (found) begin
        if (take_a) begin
          head = class_a.pop_front();
        end else begin
          head = class_b.pop_front();
        end
        rel.id     = head.id;
        rel.status = STAT_DEQ;
        expected_releases = {expected_releases, rel};
      end
    end
  endtask

  always @(posedge clk) begin
    release_t exp_rel;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_releases.size() == 0) begin
          report_mismatch("unexpected transaction, out_id", out_id, 0);
        end else begin
          exp_rel = expected_releases.pop_front();
          if (out_id !== exp_rel.id) begin
            report_mismatch("out_id", out_id, exp_rel.id);
          end
          if (out_status !== exp_rel.status) begin
            report_mismatch("out_status", out_status, exp_rel.status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_release(in_cmd, in_item_id, in_want_class);
      end
    end
    pending_count <= expected_releases.size();
  end

endmodule

@@ dv/tb_two_class_fifo_oldest_first.sv @@
// ----------------------------------------------------------------------------
// tb_two_class_fifo_oldest_first
// Drives a directed sequence and then bursts of random requests into the
// two-class FIFO under three idle patterns; the checker beside the block
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_two_class_fifo_oldest_first;
  import tcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 634;

  typedef enum int {
    FILL_A,
    FILL_B,
    MIXED,
    DRAIN,
    CHURN_B
  } burst_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_cmd;
  logic signed [FIELD_W-1:0] in_item_id;
  logic [1:0]                in_want_class;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [FIELD_W-1:0] out_id;
  logic                      out_status;

  int fail_count;
  int pending_count;
  int send_idle;
  int recv_idle;
  int items_left;
  int quiet_cycles;

  two_class_fifo_oldest_first dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_item_id   (in_item_id),
    .in_want_class(in_want_class),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_id       (out_id),
    .out_status   (out_status)
  );

  tcf_order_checker order_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_item_id   (in_item_id),
    .in_want_class(in_want_class),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_id       (out_id),
    .out_status   (out_status),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input logic cmd, input logic signed [FIELD_W-1:0] item_id,
                              input logic [1:0] want);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_item_id    <= item_id;
    in_want_class <= want;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_id(input bit positive);
    int mag;
    mag = $urandom_range(32767, 0);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: mag = 32767;
        1: mag = 1;
        default: mag = 0;
      endcase
    end
    if (positive) begin
      return (mag == 0) ? 16'sd1 : FIELD_W'(mag);
    end
    return FIELD_W'(-mag);
  endfunction

  task automatic random_burst();
    burst_mode_t mode;
    int          len;
    int          enq_pct;
    int          pos_pct;
    logic [1:0]  want;
    mode = burst_mode_t'($urandom_range(4));
    len  = (mode == CHURN_B) ? $urandom_range(150, 60) : $urandom_range(60, 10);
    case (mode)
      FILL_A:  begin enq_pct = 85; pos_pct = 95; end
      FILL_B:  begin enq_pct = 85; pos_pct = 5;  end
      MIXED:   begin enq_pct = 55; pos_pct = 50; end
      DRAIN:   begin enq_pct = 20; pos_pct = 50; end
      default: begin enq_pct = 50; pos_pct = 0;  end
    endcase
    repeat (len) begin
      if (items_left <= 0) return;
      if ($urandom_range(99) < enq_pct) begin
        send_request(CMD_ENQ, pick_id($urandom_range(99) < pos_pct),
                     2'($urandom_range(3)));
        items_left--;
      end else begin
        if (mode == CHURN_B) begin
          want = ($urandom_range(9) == 0) ? WANT_ANY : WANT_B;
        end else if ($urandom_range(24) == 0) begin
          want = WANT_NONE;
        end else begin
          want = 2'($urandom_range(2));
        end
        send_request(CMD_DEQ, FIELD_W'($urandom), want);
        if (want != WANT_NONE) items_left--;
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_ENQ;
    in_item_id    <= '0;
    in_want_class <= WANT_ANY;
    send_idle      = 32;
    recv_idle      = 71;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_request(CMD_DEQ, 16'sd0, WANT_A);
    send_request(CMD_DEQ, 16'sd0, WANT_B);
    send_request(CMD_DEQ, 16'sd0, WANT_ANY);
    send_request(CMD_DEQ, -16'sd1, WANT_NONE);
    send_request(CMD_ENQ, 16'sd32767, WANT_ANY);
    send_request(CMD_ENQ, -16'sd32767, WANT_NONE);
    send_request(CMD_ENQ, 16'sd0, WANT_B);
    send_request(CMD_ENQ, 16'sd1, WANT_A);
    send_request(CMD_ENQ, -16'sd1, WANT_ANY);
    send_request(CMD_DEQ, 16'sd0, WANT_NONE);
    send_request(CMD_DEQ, 16'sd0, WANT_ANY);
    send_request(CMD_DEQ, 16'sd0, WANT_ANY);
    send_request(CMD_DEQ, 16'sd0, WANT_B);
    send_request(CMD_DEQ, 16'sd0, WANT_A);
    send_request(CMD_DEQ, 16'sd0, WANT_A);
    send_request(CMD_DEQ, 16'sd0, WANT_ANY);
    send_request(CMD_DEQ, 16'sd0, WANT_ANY);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 32; recv_idle = 71; end
        1: begin send_idle = 71; recv_idle = 32; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      items_left = PHASE_ITEMS;
      while (items_left > 0) random_burst();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
